FILE: rtl/mscr_pkg.sv
// Shared types, codes and constants of the multi-stop grid route cost core.
package mscr_pkg;

  typedef enum logic [1:0] {
    FUNC_CELL = 2'd0,
    FUNC_DEST = 2'd1,
    FUNC_RUN  = 2'd2,
    FUNC_NOP  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    REG_GRID_SIZE  = 2'd0,
    REG_DEST_COUNT = 2'd1,
    REG_START_ROW  = 2'd2,
    REG_START_COL  = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_RELAX,
    S_GATHER,
    S_ORDER,
    S_DONE
  } state_e;

  localparam int unsigned CFG_W    = 7;
  localparam int unsigned COORD_W  = 6;
  localparam int unsigned HPORT_W  = 8;
  localparam int unsigned SLOT_W   = 3;
  localparam int unsigned COST_W   = 23;

  localparam logic [6:0] GRID_SIZE_RST  = 7'd64;
  localparam logic [2:0] DEST_COUNT_RST = 3'd1;

  // Relaxation phases of one cell: addresses go out in phases 0 to 8,
  // data comes back in phases 1 to 9, the write-back is phase 10.
  localparam logic [3:0] PH_CENTER = 4'd1;
  localparam logic [3:0] PH_ISSUE  = 4'd8;
  localparam logic [3:0] PH_NB_END = 4'd9;
  localparam logic [3:0] PH_LAST   = 4'd10;

  // Offset zero first (the cell itself), then the eight neighbors.
  localparam logic signed [1:0] DIR_DR [9] =
    '{2'sd0, -2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd1, 2'sd1};
  localparam logic signed [1:0] DIR_DC [9] =
    '{2'sd0, -2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd0, 2'sd1};

  typedef struct packed {
    logic load_en;
    logic run_init;
    logic clear_step;
    logic relax_step;
    logic gather_step;
    logic next_src;
    logic order_init;
    logic order_step;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic sweep_end;
    logic sweep_chg;
    logic gather_last;
    logic src_last;
    logic order_last;
  } status_t;

endpackage

FILE: rtl/multi_stop_grid_route_cost_core.sv
// Load cell heights and destinations, then compute the cheapest multi-stop route cost.
// A load beat is taken without leaving idle. A run beat, for each of the cnt+1 sources,
// clears the distance store, repeats relaxation sweeps until one changes nothing and
// gathers the legs; it then searches every visiting order and raises the result.
// Reset clears the controller and configuration; height and destination stores stay
// undefined until loaded. The result strobe lasts one cycle; the receiver cannot stall.
module multi_stop_grid_route_cost_core #(
  parameter int unsigned GRID_MAX    = 64,
  parameter int unsigned MAX_DEST    = 5,
  parameter int unsigned HEIGHT_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    func_i,
  input  logic [mscr_pkg::COORD_W-1:0]  row_i,
  input  logic [mscr_pkg::COORD_W-1:0]  col_i,
  input  logic [mscr_pkg::HPORT_W-1:0]  height_i,
  input  logic [mscr_pkg::SLOT_W-1:0]   slot_i,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [mscr_pkg::CFG_W-1:0]    cfg_data_i,
  output logic                          valid_o,
  output logic [mscr_pkg::COST_W-1:0]   total_cost_o
);
  import mscr_pkg::*;

  cmd_t    cmd;
  status_t stat;

  // The controller only decides which phase runs; the datapath owns every
  // counter, store and register that carries payload.
  mscr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .func_i  (func_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .valid_o (valid_o)
  );

  // Distances are found by repeated in-place relaxation sweeps over the grid,
  // which converge to the same least costs as a priority-queue search.
  mscr_dp #(
    .GRID_MAX    (GRID_MAX),
    .MAX_DEST    (MAX_DEST),
    .HEIGHT_BITS (HEIGHT_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .func_i       (func_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .height_i     (height_i),
    .slot_i       (slot_i),
    .total_cost_o (total_cost_o)
  );

  // A result beat is a single-cycle strobe.
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |=> !valid_o)
    else $error("result strobe held longer than one cycle");

  // A result only appears while a run is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_o |-> busy)
    else $error("result strobe outside a run");

  // An accepted run beat always makes the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && func_i == FUNC_RUN) |=> busy)
    else $error("run beat did not start a run");

  // The block never becomes busy on its own.
  assert property (@(posedge clk_i) disable iff (!rst_ni) $rose(busy) |-> $past(start))
    else $error("busy rose without a start beat");

endmodule

FILE: rtl/mscr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mscr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/mscr_ctrl.sv
// Controller state machine that sequences load, clear, relax, gather and order phases.
module mscr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        func_i,
  input  mscr_pkg::status_t stat_i,
  output mscr_pkg::cmd_t    cmd_o,
  output logic              busy_o,
  output logic              valid_o
);
  import mscr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (func_e'(func_i) == FUNC_RUN) begin
            cmd_o.run_init = 1'b1;
            state_d        = S_CLEAR;
          end else begin
            cmd_o.load_en = 1'b1;
          end
        end
      end
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (stat_i.clear_last) begin
          state_d = S_RELAX;
        end
      end
      S_RELAX: begin
        cmd_o.relax_step = 1'b1;
        if (stat_i.sweep_end && !stat_i.sweep_chg) begin
          state_d = S_GATHER;
        end
      end
      S_GATHER: begin
        cmd_o.gather_step = 1'b1;
        if (stat_i.gather_last) begin
          if (stat_i.src_last) begin
            cmd_o.order_init = 1'b1;
            state_d          = S_ORDER;
          end else begin
            cmd_o.next_src = 1'b1;
            state_d        = S_CLEAR;
          end
        end
      end
      S_ORDER: begin
        cmd_o.order_step = 1'b1;
        if (stat_i.order_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o  = (state_q != S_IDLE);
  assign valid_o = (state_q == S_DONE);

endmodule

FILE: rtl/mscr_dp.sv
// Datapath: configuration, stores, relaxation sweeps, leg gathering and order search.
module mscr_dp #(
  parameter int unsigned GRID_MAX    = 64,
  parameter int unsigned MAX_DEST    = 5,
  parameter int unsigned HEIGHT_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mscr_pkg::cmd_t                cmd_i,
  output mscr_pkg::status_t             stat_o,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [mscr_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic [1:0]                    func_i,
  input  logic [mscr_pkg::COORD_W-1:0]  row_i,
  input  logic [mscr_pkg::COORD_W-1:0]  col_i,
  input  logic [mscr_pkg::HPORT_W-1:0]  height_i,
  input  logic [mscr_pkg::SLOT_W-1:0]   slot_i,
  output logic [mscr_pkg::COST_W-1:0]   total_cost_o
);
  import mscr_pkg::*;

  localparam int unsigned CW    = $clog2(GRID_MAX);
  localparam int unsigned DEPTH = GRID_MAX * GRID_MAX;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned DW    = AW + HEIGHT_BITS;
  localparam int unsigned TW    = DW + 3;
  localparam int unsigned IW    = (MAX_DEST > 1) ? $clog2(MAX_DEST) : 1;
  localparam int unsigned SW    = $clog2(MAX_DEST + 1);
  localparam logic [DW-1:0] INF = '1;

  function automatic logic [CW-1:0] clampc(input logic [COORD_W-1:0] v,
                                           input logic [CW:0] nn);
    logic [CW:0] nm;
    nm = nn - 1'b1;
    if (int'(v) >= int'(nn)) clampc = nm[CW-1:0];
    else                     clampc = CW'(v);
  endfunction

  // Configuration registers.
  logic [6:0]         gs_q;
  logic [2:0]         dcnt_q;
  logic [COORD_W-1:0] srow_q, scol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gs_q   <= GRID_SIZE_RST;
      dcnt_q <= DEST_COUNT_RST;
      srow_q <= '0;
      scol_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_GRID_SIZE:  gs_q   <= cfg_data_i;
        REG_DEST_COUNT: dcnt_q <= cfg_data_i[2:0];
        REG_START_ROW:  srow_q <= cfg_data_i[COORD_W-1:0];
        REG_START_COL:  scol_q <= cfg_data_i[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CW:0]    n;
  logic [CW:0]    nm1_w;
  logic [CW-1:0]  nm1;
  logic [SW-1:0]  cnt;
  logic [IW-1:0]  cm1;

  always_comb begin
    if (gs_q == '0)                 n = (CW+1)'(1);
    else if (int'(gs_q) > GRID_MAX) n = (CW+1)'(GRID_MAX);
    else                            n = (CW+1)'(gs_q);
    nm1_w = n - 1'b1;
    nm1   = nm1_w[CW-1:0];
    if (dcnt_q == '0)                 cnt = SW'(1);
    else if (int'(dcnt_q) > MAX_DEST) cnt = SW'(MAX_DEST);
    else                              cnt = SW'(dcnt_q);
    cm1 = IW'(cnt - 1'b1);
  end

  // Destination table.
  logic [COORD_W-1:0] drow_q [MAX_DEST];
  logic [COORD_W-1:0] dcol_q [MAX_DEST];
  logic [SW-1:0]      s_q, g_q;
  logic [IW-1:0]      didx;
  logic [COORD_W-1:0] drd, dcd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_en && func_e'(func_i) == FUNC_DEST && int'(slot_i) < MAX_DEST) begin
      drow_q[IW'(slot_i)] <= row_i;
      dcol_q[IW'(slot_i)] <= col_i;
    end
  end

  assign didx = cmd_i.next_src ? IW'(s_q) : IW'(g_q);
  assign drd  = drow_q[didx];
  assign dcd  = dcol_q[didx];

  // Source cell and source counter.
  logic [CW-1:0] srcr_q, srcc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= '0;
    end else if (cmd_i.run_init) begin
      s_q <= '0;
    end else if (cmd_i.next_src) begin
      s_q <= s_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.run_init) begin
      srcr_q <= clampc(srow_q, n);
      srcc_q <= clampc(scol_q, n);
    end else if (cmd_i.next_src) begin
      srcr_q <= clampc(drd, n);
      srcc_q <= clampc(dcd, n);
    end
  end

  // Cell walk and relaxation.
  logic [CW-1:0]       r_q, c_q;
  logic [3:0]          ph_q;
  logic                chg_q;
  logic                cell_last;
  logic                issue;
  logic [3:0]          kk;
  logic signed [CW+1:0] nr, nc;
  logic                n_ok;
  logic [AW-1:0]       naddr, caddr, gaddr;
  logic                ok_q;
  logic [DW-1:0]       dcur_q;
  logic [HEIGHT_BITS-1:0] hc_q, h_rd, hdiff;
  logic [DW-1:0]       d_rd;
  logic [DW:0]         cand;
  logic                improve;
  logic                step_cell;

  assign cell_last = (r_q == nm1) && (c_q == nm1);
  assign issue     = (ph_q <= PH_ISSUE);
  assign kk        = issue ? ph_q : 4'd0;

  always_comb begin
    nr    = $signed({2'b00, r_q}) + (CW+2)'(DIR_DR[kk]);
    nc    = $signed({2'b00, c_q}) + (CW+2)'(DIR_DC[kk]);
    n_ok  = (nr >= 0) && (nc >= 0) &&
            (nr < $signed({1'b0, n})) && (nc < $signed({1'b0, n}));
    naddr = AW'(nr[CW-1:0]) * AW'(GRID_MAX) + AW'(nc[CW-1:0]);
    caddr = AW'(r_q) * AW'(GRID_MAX) + AW'(c_q);
    gaddr = AW'(clampc(drd, n)) * AW'(GRID_MAX) + AW'(clampc(dcd, n));
  end

  always_comb begin
    hdiff   = (hc_q > h_rd) ? (hc_q - h_rd) : (h_rd - hc_q);
    cand    = {1'b0, d_rd} + (DW+1)'(hdiff);
    improve = cmd_i.relax_step && ph_q > PH_CENTER && ph_q <= PH_NB_END && ok_q &&
              (d_rd != INF) && (cand < {1'b0, dcur_q});
  end

  assign step_cell = cmd_i.clear_step || (cmd_i.relax_step && ph_q == PH_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q   <= '0;
      c_q   <= '0;
      ph_q  <= '0;
      chg_q <= 1'b0;
      ok_q  <= 1'b0;
    end else begin
      ok_q <= cmd_i.relax_step && issue && n_ok;
      if (cmd_i.run_init) begin
        r_q   <= '0;
        c_q   <= '0;
        ph_q  <= '0;
        chg_q <= 1'b0;
      end else begin
        if (cmd_i.relax_step) begin
          ph_q <= (ph_q == PH_LAST) ? 4'd0 : ph_q + 4'd1;
        end
        if (step_cell) begin
          if (c_q == nm1) begin
            c_q <= '0;
            r_q <= (r_q == nm1) ? '0 : r_q + 1'b1;
          end else begin
            c_q <= c_q + 1'b1;
          end
        end
        if (step_cell && cell_last) begin
          chg_q <= 1'b0;
        end else if (improve) begin
          chg_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.relax_step && ph_q == PH_CENTER) begin
      dcur_q <= d_rd;
      hc_q   <= h_rd;
    end else if (improve) begin
      dcur_q <= cand[DW-1:0];
    end
  end

  // Height and distance stores.
  logic                   h_we;
  logic [AW-1:0]          h_waddr;
  logic                   d_we;
  logic [DW-1:0]          d_wdata;
  logic [AW-1:0]          d_raddr;

  assign h_we    = cmd_i.load_en && func_e'(func_i) == FUNC_CELL &&
                   int'(row_i) < GRID_MAX && int'(col_i) < GRID_MAX;
  assign h_waddr = AW'(row_i) * AW'(GRID_MAX) + AW'(col_i);
  assign d_we    = step_cell;
  assign d_wdata = cmd_i.clear_step ?
                   (((r_q == srcr_q) && (c_q == srcc_q)) ? '0 : INF) : dcur_q;
  assign d_raddr = cmd_i.gather_step ? gaddr : naddr;

  mscr_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(DEPTH)) u_height_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (HEIGHT_BITS'(height_i)),
    .raddr_i (naddr),
    .rdata_o (h_rd)
  );

  mscr_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (caddr),
    .wdata_i (d_wdata),
    .raddr_i (d_raddr),
    .rdata_o (d_rd)
  );

  // Leg gathering.
  logic [DW-1:0] leg_q [MAX_DEST+1][MAX_DEST];
  logic          gv_q;
  logic [IW-1:0] gi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_q  <= '0;
      gv_q <= 1'b0;
    end else begin
      gv_q <= cmd_i.gather_step && (g_q != cnt);
      if (cmd_i.gather_step) begin
        g_q <= (g_q == cnt) ? '0 : g_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    gi_q <= IW'(g_q);
    if (gv_q) begin
      leg_q[s_q][gi_q] <= d_rd;
    end
  end

  // Visiting order search: every digit tuple is walked, non-permutations
  // are dropped at the end of their walk.
  logic [IW-1:0]       tup_q [MAX_DEST];
  logic [IW-1:0]       tup_n [MAX_DEST];
  logic [IW-1:0]       j_q;
  logic [SW-1:0]       from_q;
  logic [TW-1:0]       acc_q, acc_n, best_q;
  logic [MAX_DEST-1:0] used_q;
  logic                ook_q, ook_n;
  logic [IW-1:0]       to;
  logic                last_step, all_max, carry;

  always_comb begin
    to        = tup_q[j_q];
    acc_n     = acc_q + TW'(leg_q[from_q][to]);
    ook_n     = ook_q && !used_q[to];
    last_step = (int'(j_q) + 1 == int'(cnt));
    all_max   = 1'b1;
    carry     = 1'b1;
    for (int i = 0; i < MAX_DEST; i++) begin
      tup_n[i] = tup_q[i];
      if (i < int'(cnt)) begin
        if (tup_q[i] != cm1) all_max = 1'b0;
        if (carry) begin
          if (tup_q[i] == cm1) begin
            tup_n[i] = '0;
          end else begin
            tup_n[i] = tup_q[i] + 1'b1;
            carry    = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.order_init) begin
      for (int i = 0; i < MAX_DEST; i++) tup_q[i] <= '0;
      j_q    <= '0;
      from_q <= '0;
      acc_q  <= '0;
      used_q <= '0;
      ook_q  <= 1'b1;
      best_q <= '1;
    end else if (cmd_i.order_step) begin
      if (last_step) begin
        if (ook_n && acc_n < best_q) best_q <= acc_n;
        for (int i = 0; i < MAX_DEST; i++) tup_q[i] <= tup_n[i];
        j_q    <= '0;
        from_q <= '0;
        acc_q  <= '0;
        used_q <= '0;
        ook_q  <= 1'b1;
      end else begin
        j_q        <= j_q + 1'b1;
        from_q     <= SW'(to) + 1'b1;
        acc_q      <= acc_n;
        used_q[to] <= 1'b1;
        ook_q      <= ook_n;
      end
    end
  end

  assign total_cost_o = COST_W'(best_q);

  assign stat_o.clear_last  = cell_last;
  assign stat_o.sweep_end   = (ph_q == PH_LAST) && cell_last;
  assign stat_o.sweep_chg   = chg_q;
  assign stat_o.gather_last = (g_q == cnt);
  assign stat_o.src_last    = (s_q == cnt);
  assign stat_o.order_last  = last_step && all_max;

endmodule

FILE: tb/sv/multi_stop_grid_route_cost_core_test.sv
// Self-checking testbench of the multi-stop grid route cost core.
module multi_stop_grid_route_cost_core_test;
  import mscr_pkg::*;

  localparam int unsigned SIDE      = 64;
  localparam int unsigned DEST_SLOTS = 5;
  localparam int unsigned STALL_LIMIT = 2000000;

  // The route board keeps its own copy of the block's stores and registers,
  // predicts the cost of every run beat and matches the results against it.
  class route_board;
    logic [7:0]        heights [SIDE*SIDE];
    logic [5:0]        dest_row [DEST_SLOTS];
    logic [5:0]        dest_col [DEST_SLOTS];
    logic [6:0]        grid_reg;
    logic [2:0]        count_reg;
    logic [5:0]        srow_reg;
    logic [5:0]        scol_reg;
    int                dist_map [SIDE*SIDE];
    int                legs [DEST_SLOTS+1][DEST_SLOTS];
    longint            best;
    logic [COST_W-1:0] costs_due [$];
    int                errors;

    function new();
      grid_reg  = GRID_SIZE_RST;
      count_reg = DEST_COUNT_RST;
      srow_reg  = '0;
      scol_reg  = '0;
      errors    = 0;
    endfunction

    function void write_reg(reg_e idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_GRID_SIZE:  grid_reg  = value;
        REG_DEST_COUNT: count_reg = value[2:0];
        REG_START_ROW:  srow_reg  = value[5:0];
        REG_START_COL:  scol_reg  = value[5:0];
        default: ;
      endcase
    endfunction

    function int clamp(int v, int n);
      return (v >= n) ? n - 1 : v;
    endfunction

    // Relax the whole grid repeatedly until no distance improves.
    function void flood(int sr, int sc, int n);
      bit changed;
      int cand, nb, hd;
      foreach (dist_map[i]) dist_map[i] = -1;
      dist_map[sr*SIDE+sc] = 0;
      do begin
        changed = 0;
        for (int r = 0; r < n; r++) begin
          for (int c = 0; c < n; c++) begin
            for (int dr = -1; dr <= 1; dr++) begin
              for (int dc = -1; dc <= 1; dc++) begin
                if ((dr != 0 || dc != 0) && r+dr >= 0 && c+dc >= 0 &&
                    r+dr < n && c+dc < n) begin
                  nb = (r+dr)*SIDE + c + dc;
                  if (dist_map[nb] >= 0) begin
                    hd = int'(heights[r*SIDE+c]) - int'(heights[nb]);
                    cand = dist_map[nb] + ((hd < 0) ? -hd : hd);
                    if (dist_map[r*SIDE+c] < 0 || cand < dist_map[r*SIDE+c]) begin
                      dist_map[r*SIDE+c] = cand;
                      changed = 1;
                    end
                  end
                end
              end
            end
          end
        end
      end while (changed);
    endfunction

    function void walk_orders(int from, int used, int placed, longint acc, int k);
      if (placed == k) begin
        if (acc < best) best = acc;
        return;
      end
      for (int i = 0; i < k; i++)
        if (!used[i]) walk_orders(i + 1, used | (1 << i), placed + 1,
                                  acc + legs[from][i], k);
    endfunction

    function logic [COST_W-1:0] route_cost();
      int n, k, sr, sc;
      n = (grid_reg == 0) ? 1 : (grid_reg > SIDE) ? SIDE : grid_reg;
      k = (count_reg == 0) ? 1 : (count_reg > DEST_SLOTS) ? DEST_SLOTS : count_reg;
      for (int s = 0; s <= k; s++) begin
        sr = (s == 0) ? srow_reg : dest_row[s-1];
        sc = (s == 0) ? scol_reg : dest_col[s-1];
        flood(clamp(sr, n), clamp(sc, n), n);
        for (int i = 0; i < k; i++)
          legs[s][i] = dist_map[clamp(dest_row[i], n)*SIDE + clamp(dest_col[i], n)];
      end
      best = 64'h7fff_ffff_ffff_ffff;
      walk_orders(0, 0, 0, 0, k);
      return best[COST_W-1:0];
    endfunction

    function void note_beat(func_e f, logic [5:0] row, logic [5:0] col,
                            logic [7:0] h, logic [2:0] slot);
      case (f)
        FUNC_CELL: heights[row*SIDE+col] = h;
        FUNC_DEST:
          if (slot < DEST_SLOTS) begin
            dest_row[slot] = row;
            dest_col[slot] = col;
          end
        FUNC_RUN:  costs_due.push_back(route_cost());
        default: ;
      endcase
    endfunction

    function void check_cost(logic [COST_W-1:0] got);
      logic [COST_W-1:0] want;
      if (costs_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time, got);
        errors++;
        return;
      end
      want = costs_due.pop_front();
      if (got !== want) begin
        $display("%0t: total_cost mismatch, expected %0d, actual %0d", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          func_i = FUNC_NOP;
  logic [COORD_W-1:0]  row_i = '0;
  logic [COORD_W-1:0]  col_i = '0;
  logic [HPORT_W-1:0]  height_i = '0;
  logic [SLOT_W-1:0]   slot_i = '0;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_idx_i = REG_GRID_SIZE;
  logic [CFG_W-1:0]    cfg_data_i = '0;
  logic                valid_o;
  logic [COST_W-1:0]   total_cost_o;

  route_board board = new();
  int         beats_sent = 0;
  int         quiet_cycles = 0;

  // What the stimulus knows to be loaded, so that no run reads an unwritten entry.
  bit         cell_loaded [SIDE*SIDE];
  bit         dest_loaded [DEST_SLOTS];
  int         cur_n = SIDE;
  int         cur_k = 1;

  multi_stop_grid_route_cost_core dut (
    .clk_i, .rst_ni, .start, .busy, .func_i, .row_i, .col_i, .height_i, .slot_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .valid_o, .total_cost_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Results cannot be held off, so every strobe is checked at the edge that ends it.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) board.check_cost(total_cost_o);
  end

  // The watchdog counts cycles in which neither a beat nor a result is accepted.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Start stays high between back-to-back beats; only a gap lowers it.
  task automatic pause_sender();
    int roll, len;
    roll = $urandom_range(0, 99);
    if (roll < 55) return;
    len = (roll < 95) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    start <= 1'b0;
    repeat (len) @(posedge clk_i);
  endtask

  task automatic send_beat(func_e f, int row, int col, int h, int slot);
    start    <= 1'b1;
    func_i   <= f;
    row_i    <= COORD_W'(row);
    col_i    <= COORD_W'(col);
    height_i <= HPORT_W'(h);
    slot_i   <= SLOT_W'(slot);
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    board.note_beat(f, COORD_W'(row), COORD_W'(col), HPORT_W'(h), SLOT_W'(slot));
    beats_sent++;
    if (f == FUNC_CELL) cell_loaded[row*SIDE+col] = 1'b1;
    if (f == FUNC_DEST && slot < DEST_SLOTS) dest_loaded[slot] = 1'b1;
    pause_sender();
  endtask

  // Wait until every predicted cost has come back and the block has gone quiet.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (board.costs_due.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_regs(int grid, int count, int srow, int scol);
    reg_e idx [4];
    int   val [4];
    idx = '{REG_GRID_SIZE, REG_DEST_COUNT, REG_START_ROW, REG_START_COL};
    val = '{grid, count, srow, scol};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[i];
      cfg_data_i <= CFG_W'(val[i]);
      @(posedge clk_i);
      board.write_reg(idx[i], CFG_W'(val[i]));
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    cur_n = (grid == 0) ? 1 : (grid > SIDE) ? SIDE : grid;
    cur_k = (count == 0) ? 1 : (count > DEST_SLOTS) ? DEST_SLOTS : count;
  endtask

  // A random beat that does not threaten a later run: stray loads, ignored
  // destination slots and the unused function code.
  task automatic noise_beat();
    case ($urandom_range(0, 3))
      0: send_beat(FUNC_NOP, $urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 255), $urandom_range(0, 7));
      1: send_beat(FUNC_DEST, $urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 255), $urandom_range(DEST_SLOTS, 7));
      2: send_beat(FUNC_CELL, $urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 255), $urandom_range(0, 7));
      default: send_beat(FUNC_DEST, $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 255), $urandom_range(0, DEST_SLOTS-1));
    endcase
  endtask

  // One well-formed sequence: fill every cell and destination the run will read,
  // rewrite a few at random, sprinkle noise, then start the search.
  task automatic load_and_run();
    int span;
    span = ($urandom_range(0, 3) == 0) ? 255 : 15;
    for (int r = 0; r < cur_n; r++) begin
      for (int c = 0; c < cur_n; c++) begin
        if (!cell_loaded[r*SIDE+c] || $urandom_range(0, 3) == 0)
          send_beat(FUNC_CELL, r, c, $urandom_range(0, span), $urandom_range(0, 7));
        if ($urandom_range(0, 15) == 0) noise_beat();
      end
    end
    for (int s = 0; s < cur_k; s++) begin
      if (!dest_loaded[s] || $urandom_range(0, 1) == 0)
        send_beat(FUNC_DEST, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                             : $urandom_range(0, cur_n - 1),
                  $urandom_range(0, cur_n - 1), $urandom_range(0, 255), s);
    end
    send_beat(FUNC_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
              $urandom_range(0, 255), $urandom_range(0, 7));
  endtask

  initial begin
    int grid, count;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: a zero grid size saturates to one cell, a zero count to one
    // destination, and a start or destination beyond the grid is pulled in.
    set_regs(0, 0, 63, 63);
    send_beat(FUNC_CELL, 0, 0, 255, 0);
    send_beat(FUNC_DEST, 63, 63, 0, 0);
    send_beat(FUNC_NOP, 63, 63, 255, 7);
    send_beat(FUNC_DEST, 5, 5, 0, 7);
    send_beat(FUNC_RUN, 0, 0, 0, 0);

    // An oversized count saturates to five; heights swing between the extremes.
    set_regs(3, 7, 0, 0);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        send_beat(FUNC_CELL, r, c, ((r + c) % 2) ? 255 : 0, 0);
    send_beat(FUNC_DEST, 0, 0, 0, 0);
    send_beat(FUNC_DEST, 2, 2, 0, 1);
    send_beat(FUNC_DEST, 0, 2, 0, 2);
    send_beat(FUNC_DEST, 2, 1, 0, 3);
    send_beat(FUNC_DEST, 63, 0, 0, 4);
    send_beat(FUNC_RUN, 0, 0, 0, 0);
    set_regs(2, 5, 63, 63);
    send_beat(FUNC_RUN, 0, 0, 0, 0);

    // Random sequences on small grids; five destinations only now and then,
    // since the order search grows fast with the count.
    while (beats_sent < 500) begin
      if (board.costs_due.size() == 0 || $urandom_range(0, 2) != 0) begin
        grid  = $urandom_range(0, 6);
        count = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
        set_regs(grid, count, $urandom_range(0, 63), $urandom_range(0, 63));
      end
      load_and_run();
      if ($urandom_range(0, 2) == 0) noise_beat();
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (board.errors == 0 && board.costs_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: multi_stop_grid_route_cost_core.f
rtl/mscr_pkg.sv
rtl/mscr_ram.sv
rtl/mscr_ctrl.sv
rtl/mscr_dp.sv
rtl/multi_stop_grid_route_cost_core.sv
tb/sv/multi_stop_grid_route_cost_core_test.sv
